[rtl/impft_pkg.sv]
`default_nettype none
package impft_pkg;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_DRAIN  = 2'd1,
    KIND_END    = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_RESOLVE = 2'd1,
    ST_DRAIN   = 2'd2,
    ST_MARK    = 2'd3
  } state_t;

  typedef enum logic {
    ACT_LOOKUP = 1'b0,
    ACT_DRAIN  = 1'b1
  } action_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic resolve;
    logic drain_word;
    logic mark;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic fresh_zero;
    logic drain_last;
  } sts_t;

endpackage
`default_nettype wire

[rtl/impft_in_if.sv]
`default_nettype none
interface impft_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] host_ip;
  logic [47:0] host_mac;

  modport source (output valid, output action, output host_ip, output host_mac,
                  input ready);
  modport sink (input valid, input action, input host_ip, input host_mac,
                output ready);
endinterface
`default_nettype wire

[rtl/impft_out_if.sv]
`default_nettype none
interface impft_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  entry_kind;
  logic [4:0]  slot_index;
  logic [31:0] pair_ip;
  logic [47:0] pair_mac;
  logic        final_of_run;

  modport source (output valid, output entry_kind, output slot_index, output pair_ip,
                  output pair_mac, output final_of_run, input ready);
  modport sink (input valid, input entry_kind, input slot_index, input pair_ip,
                input pair_mac, input final_of_run, output ready);
endinterface
`default_nettype wire

[rtl/impft_ctrl.sv]
`default_nettype none
module impft_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_action,
  output logic               in_ready,
  input  wire impft_pkg::sts_t sts,
  output impft_pkg::cmd_t    cmd
);

  impft_pkg::state_t state_r;
  impft_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= impft_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      impft_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (in_action == impft_pkg::ACT_LOOKUP) begin
            state_nxt = impft_pkg::ST_RESOLVE;
          end else if (sts.fresh_zero) begin
            state_nxt = impft_pkg::ST_MARK;
          end else begin
            state_nxt = impft_pkg::ST_DRAIN;
          end
        end
      end
      impft_pkg::ST_RESOLVE: begin
        if (sts.out_free) begin
          cmd.resolve = 1'b1;
          state_nxt   = impft_pkg::ST_IDLE;
        end
      end
      impft_pkg::ST_DRAIN: begin
        if (sts.out_free) begin
          cmd.drain_word = 1'b1;
          if (sts.drain_last) begin
            state_nxt = impft_pkg::ST_MARK;
          end
        end
      end
      impft_pkg::ST_MARK: begin
        if (sts.out_free) begin
          cmd.mark  = 1'b1;
          state_nxt = impft_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = impft_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/impft_dp.sv]
`default_nettype none
module impft_dp #(
  parameter int ENTRIES = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [31:0]     in_ip,
  input  wire logic [47:0]     in_mac,
  input  wire impft_pkg::cmd_t cmd,
  output impft_pkg::sts_t      sts,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output logic [1:0]           out_kind,
  output logic [4:0]           out_slot,
  output logic [31:0]          out_ip,
  output logic [47:0]          out_mac,
  output logic                 out_final
);

  localparam int SW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW:0]   ENT_W     = (CW + 1)'(ENTRIES);
  localparam logic [CW-1:0] ENT_C     = CW'(ENTRIES);
  localparam logic [SW-1:0] LAST_SLOT = SW'(ENTRIES - 1);

  logic [31:0]        ip_tab_r  [ENTRIES];
  logic [47:0]        mac_tab_r [ENTRIES];

  logic [CW-1:0]      filled_r;
  logic [SW-1:0]      newest_r;
  logic [CW-1:0]      fresh_r;
  logic [ENTRIES-1:0] match_r;
  logic [31:0]        key_ip_r;
  logic [47:0]        key_mac_r;
  logic [SW-1:0]      drain_slot_r;
  logic [CW-1:0]      drain_left_r;

  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic [4:0]         out_slot_r;
  logic [31:0]        out_ip_r;
  logic [47:0]        out_mac_r;
  logic               out_final_r;

  logic [ENTRIES-1:0] match_nxt;
  logic [ENTRIES-1:0] upper_hits;
  logic [ENTRIES-1:0] pick_vec;
  logic [SW-1:0]      hit_slot;
  logic               hit;
  logic [CW-1:0]      filled_inc;
  logic [SW-1:0]      newest_inc;
  logic [SW-1:0]      ins_slot;
  logic [CW-1:0]      fresh_inc;
  logic [CW-1:0]      back_d;
  logic [CW:0]        newest_w;
  logic [CW:0]        back_w;
  logic [CW:0]        start_w;
  logic [SW-1:0]      drain_slot_inc;
  logic               out_load;

  // parallel compare of the filled slots against the incoming pair
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = (ip_tab_r[i] == in_ip) && (mac_tab_r[i] == in_mac) &&
                     (CW'(i) < filled_r);
    end
  end

  // newest first: slots at or below newest win, highest index first, then the wrapped part
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      upper_hits[i] = match_r[i] && (SW'(i) <= newest_r);
    end
    pick_vec = (|upper_hits) ? upper_hits : match_r;
    hit_slot = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (pick_vec[i]) begin
        hit_slot = SW'(i);
      end
    end
  end

  assign hit        = |match_r;
  assign filled_inc = (filled_r < ENT_C) ? filled_r + CW'(1) : filled_r;
  assign newest_inc = (newest_r == LAST_SLOT) ? '0 : newest_r + SW'(1);
  assign ins_slot   = (filled_inc > CW'(1)) ? newest_inc : newest_r;
  assign fresh_inc  = (fresh_r < ENT_C) ? fresh_r + CW'(1) : fresh_r;

  // oldest fresh slot
  assign back_d   = fresh_r - CW'(1);
  assign newest_w = (CW + 1)'(newest_r);
  assign back_w   = {1'b0, back_d};
  assign start_w  = (newest_w >= back_w) ? newest_w - back_w : newest_w + ENT_W - back_w;

  assign drain_slot_inc = (drain_slot_r == LAST_SLOT) ? '0 : drain_slot_r + SW'(1);

  assign out_load = cmd.resolve || cmd.drain_word || cmd.mark;

  assign sts.out_free   = !out_valid_r || out_ready;
  assign sts.fresh_zero = (fresh_r == '0);
  assign sts.drain_last = (drain_left_r == CW'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      newest_r    <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.resolve && !hit) begin
        filled_r <= filled_inc;
        newest_r <= ins_slot;
        fresh_r  <= fresh_inc;
      end
      if (cmd.mark) begin
        fresh_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      match_r      <= match_nxt;
      key_ip_r     <= in_ip;
      key_mac_r    <= in_mac;
      drain_slot_r <= start_w[SW-1:0];
      drain_left_r <= fresh_r;
    end
    if (cmd.drain_word) begin
      drain_slot_r <= drain_slot_inc;
      drain_left_r <= drain_left_r - CW'(1);
    end
    if (cmd.resolve && !hit) begin
      ip_tab_r[ins_slot]  <= key_ip_r;
      mac_tab_r[ins_slot] <= key_mac_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.resolve) begin
      out_kind_r  <= impft_pkg::KIND_LOOKUP;
      out_slot_r  <= hit ? 5'(hit_slot) : 5'(ins_slot);
      out_ip_r    <= '0;
      out_mac_r   <= '0;
      out_final_r <= 1'b1;
    end else if (cmd.drain_word) begin
      out_kind_r  <= impft_pkg::KIND_DRAIN;
      out_slot_r  <= 5'(drain_slot_r);
      out_ip_r    <= ip_tab_r[drain_slot_r];
      out_mac_r   <= mac_tab_r[drain_slot_r];
      out_final_r <= 1'b0;
    end else if (cmd.mark) begin
      out_kind_r  <= impft_pkg::KIND_END;
      out_slot_r  <= '0;
      out_ip_r    <= '0;
      out_mac_r   <= '0;
      out_final_r <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_slot  = out_slot_r;
  assign out_ip    = out_ip_r;
  assign out_mac   = out_mac_r;
  assign out_final = out_final_r;

endmodule
`default_nettype wire

[rtl/ip_mac_pair_fifo_table_unit.sv]
// Lookup: the accept edge registers the all-slot compare; the newest-first select, table write
//   and answer-word load follow once the output is free; no new word is taken until then.
// Drain of n fresh entries: n words, one per cycle while the output is free, then an end word.
// A new word is accepted while the previous answer still waits in the output register.
// Synchronous active-low reset empties the table and clears the counts; no clearing pass.
`default_nettype none
module ip_mac_pair_fifo_table_unit #(
  parameter int ENTRIES = 32
) (
  input wire logic   clk,
  input wire logic   rst_n,
  impft_in_if.sink   in_ch,
  impft_out_if.source out_ch
);

  impft_pkg::cmd_t cmd;
  impft_pkg::sts_t sts;

  impft_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_action(in_ch.action),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  impft_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ip    (in_ch.host_ip),
    .in_mac   (in_ch.host_mac),
    .cmd      (cmd),
    .sts      (sts),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_kind (out_ch.entry_kind),
    .out_slot (out_ch.slot_index),
    .out_ip   (out_ch.pair_ip),
    .out_mac  (out_ch.pair_mac),
    .out_final(out_ch.final_of_run)
  );

`ifndef ASSERT_OFF
  a_lookup_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && (in_ch.action == impft_pkg::ACT_LOOKUP)) |=> !in_ch.ready)
    else $error("input taken while a lookup is unresolved");

  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.capture, cmd.resolve, cmd.drain_word, cmd.mark}))
    else $error("more than one datapath command in a cycle");

  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.entry_kind == impft_pkg::KIND_DRAIN)) |-> !in_ch.ready)
    else $error("input ready while a drain is still running");
`endif

endmodule
`default_nettype wire

[test/tb_top.sv]
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 32;

  typedef struct {
    impft_pkg::kind_t kind;
    logic [4:0]       slot;
    logic [31:0]      ip;
    logic [47:0]      mac;
    logic             fin;
  } table_word_t;

  class pair_table_board;
    logic [31:0] ip_tbl [SLOTS];
    logic [47:0] mac_tbl [SLOTS];
    int filled;
    int newest;
    int fresh;
    int errors;
    table_word_t due_words [$];

    function new();
      filled = 0;
      newest = 0;
      fresh  = 0;
      errors = 0;
    endfunction

    function int pending();
      return due_words.size();
    endfunction

    task report(string msg);
      $display("ERROR %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void push_word(impft_pkg::kind_t kind, int slot, logic [31:0] ip,
                            logic [47:0] mac, logic fin);
      table_word_t w;
      w.kind = kind;
      w.slot = slot[4:0];
      w.ip   = ip;
      w.mac  = mac;
      w.fin  = fin;
      due_words.push_back(w);
    endfunction

    // accepted input word -> expected output words
    function void note_word(impft_pkg::action_t act, logic [31:0] ip, logic [47:0] mac);
      int  s;
      bit  hit;
      int  back;
      s   = 0;
      hit = 1'b0;
      if (act == impft_pkg::ACT_LOOKUP) begin
        // newest to oldest
        for (int i = 0; i < filled && !hit; i++) begin
          s = (newest + SLOTS - i) % SLOTS;
          if (ip_tbl[s] == ip && mac_tbl[s] == mac) hit = 1'b1;
        end
        if (!hit) begin
          if (filled < SLOTS) filled++;
          if (filled > 1) newest = (newest + 1) % SLOTS;
          ip_tbl[newest]  = ip;
          mac_tbl[newest] = mac;
          if (fresh < SLOTS) fresh++;
          s = newest;
        end
        push_word(impft_pkg::KIND_LOOKUP, s, '0, '0, 1'b1);
      end else begin
        for (back = fresh; back > 0; back--) begin
          s = (newest + SLOTS - (back - 1)) % SLOTS;
          push_word(impft_pkg::KIND_DRAIN, s, ip_tbl[s], mac_tbl[s], 1'b0);
        end
        push_word(impft_pkg::KIND_END, 0, '0, '0, 1'b1);
        fresh = 0;
      end
    endfunction

    task check_word(logic [1:0] kind, logic [4:0] slot, logic [31:0] ip, logic [47:0] mac,
                    logic fin);
      table_word_t w;
      if (due_words.size() == 0) begin
        report($sformatf("unexpected word kind %0d slot %0d", kind, slot));
        return;
      end
      w = due_words.pop_front();
      if (kind !== w.kind)
        report($sformatf("entry_kind %0d, want %0d", kind, w.kind));
      if (slot !== w.slot)
        report($sformatf("slot_index %0d, want %0d", slot, w.slot));
      if (ip !== w.ip)
        report($sformatf("pair_ip %h, want %h", ip, w.ip));
      if (mac !== w.mac)
        report($sformatf("pair_mac %h, want %h", mac, w.mac));
      if (fin !== w.fin)
        report($sformatf("final_of_run %b, want %b", fin, w.fin));
    endtask
  endclass

  logic clk;
  logic rst_n;

  impft_in_if  in_ch();
  impft_out_if out_ch();

  ip_mac_pair_fifo_table_unit #(.ENTRIES(SLOTS)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pair_table_board sb = new();

  int burst_left = 0;
  logic [31:0] seen_ips [$];
  logic [47:0] seen_macs [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("ip_mac_pair_fifo_table_unit: mismatch");
    $finish;
  end

  task send_word(impft_pkg::action_t act, logic [31:0] ip, logic [47:0] mac);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.host_ip  <= ip;
    in_ch.host_mac <= mac;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(act, ip, mac);
    if (act == impft_pkg::ACT_LOOKUP) begin
      seen_ips.push_back(ip);
      seen_macs.push_back(mac);
    end
    burst_left--;
  endtask

  task send_drain();
    send_word(impft_pkg::ACT_DRAIN, $urandom(), {16'($urandom()), $urandom()});
  endtask

  task send_random_lookup();
    logic [31:0] ip;
    logic [47:0] mac;
    int          pick;
    int          r;
    r  = $urandom_range(0, 9);
    ip = $urandom();
    mac = {16'($urandom()), $urandom()};
    if (seen_ips.size() != 0 && r < 6) begin
      pick = $urandom_range(0, seen_ips.size() - 1);
      ip   = seen_ips[pick];
      if (r < 4) mac = seen_macs[pick];
      else if (r == 5) begin
        ip  = $urandom();
        mac = seen_macs[pick];
      end
    end
    send_word(impft_pkg::ACT_LOOKUP, ip, mac);
  endtask

  initial begin
    in_ch.valid    <= 1'b0;
    in_ch.action   <= impft_pkg::ACT_LOOKUP;
    in_ch.host_ip  <= '0;
    in_ch.host_mac <= '0;
    rst_n          <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    send_drain();
    send_word(impft_pkg::ACT_LOOKUP, 32'h0, 48'h0);
    send_word(impft_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_word(impft_pkg::ACT_LOOKUP, 32'h0, 48'h0);
    send_word(impft_pkg::ACT_LOOKUP, 32'h0, 48'hFFFF_FFFF_FFFF);
    send_word(impft_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0);
    send_word(impft_pkg::ACT_LOOKUP, 32'hAAAA_AAAA, 48'h5555_5555_5555);
    send_word(impft_pkg::ACT_LOOKUP, 32'h5555_5555, 48'hAAAA_AAAA_AAAA);
    send_word(impft_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    send_drain();
    send_drain();
    send_word(impft_pkg::ACT_LOOKUP, 32'hAAAA_AAAA, 48'h5555_5555_5555);
    send_word(impft_pkg::ACT_LOOKUP, 32'h0A00_0001, 48'h0011_2233_4455);
    send_word(impft_pkg::ACT_LOOKUP, 32'h0A00_0001, 48'h0011_2233_4455);
    send_drain();

    // random: long run without drains first so the ring wraps and fresh saturates
    for (int n = 0; n < 200; n++) begin
      if (n >= 90 && $urandom_range(0, 11) == 0) send_drain();
      else send_random_lookup();
    end
    send_drain();
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ip_mac_pair_fifo_table_unit: match");
    end else begin
      $display("ip_mac_pair_fifo_table_unit: mismatch");
    end
    $finish;
  end

  // receiver: stall pattern changes mode every stretch
  initial begin
    int mode;
    int mode_left;
    mode      = 0;
    mode_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        sb.check_word(out_ch.entry_kind, out_ch.slot_index, out_ch.pair_ip, out_ch.pair_mac,
                      out_ch.final_of_run);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 120);
      end
      mode_left--;
      case (mode)
        0: begin
          out_ch.ready <= 1'b1;
        end
        1: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_ch.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

endmodule
`default_nettype wire
